### design/csa_pkg.sv
// ----------------------------------------------------------------------------
// Command slot allocator package
// Field widths, operation codes and status codes shared by the allocator.
// ----------------------------------------------------------------------------
package csa_pkg;

   localparam int OP_W       = 2;
   localparam int SLOT_W     = 7;
   localparam int STATUS_W   = 2;
   localparam int IRQ_WORD_W = 2;
   localparam int MASK_W     = 32;
   localparam int BIT_SEL_W  = 5;
   localparam int ACTIVE_W   = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // One past the largest value of the active-slot register; every granted slot lies below it.
   localparam int GRANT_LIMIT = 2 ** ACTIVE_W;

   typedef enum logic [OP_W-1:0] {
      OP_ACQUIRE = 2'd0,
      OP_RELEASE = 2'd1,
      OP_CLEAR   = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK           = 2'd0,
      STATUS_NO_SLOT      = 2'd1,
      STATUS_CONTROL_BUSY = 2'd2,
      STATUS_UNUSED       = 2'd3
   } status_type;

   // Register index within the configuration space.
   localparam logic [CSR_ADDR_W-3:0] REG_ACTIVE_SLOTS = '0;

endpackage

### design/command_slot_allocator.sv
// ----------------------------------------------------------------------------
// Command slot allocator
// Busy bitmap of command-queue slots with first-free grant, release, clear
// and a dedicated control slot; reports the interrupt word and bit per slot.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake             payload
//   req      in         req_valid / req_stall req_op, req_is_control, req_slot_in
//   rsp      out        rsp_valid / rsp_stall rsp_status, rsp_slot_out,
//                                             rsp_irq_word, rsp_irq_bit_mask,
//                                             rsp_configured
//   csr      in/out     csr_psel / penable    active_slots at byte address 0
//
// One word per cycle sustained while rsp is not stalled; an accepted word goes
// from the input register to the result register. The lowest-free search between
// the two registers sets the clock rate. Reset clears the busy map, both flags
// and active_slots, so normal acquires are refused until active_slots is set.
// A stalled rsp holds its word while the input register takes one more;
// req_stall rises only once that word is waiting as well.
//
module command_slot_allocator #(
   parameter int SLOT_COUNT = 128
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [csa_pkg::OP_W-1:0]              req_op,
   input  logic                                  req_is_control,
   input  logic [csa_pkg::SLOT_W-1:0]            req_slot_in,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [csa_pkg::STATUS_W-1:0]          rsp_status,
   output logic [csa_pkg::SLOT_W-1:0]            rsp_slot_out,
   output logic [csa_pkg::IRQ_WORD_W-1:0]        rsp_irq_word,
   output logic [csa_pkg::MASK_W-1:0]            rsp_irq_bit_mask,
   output logic                                  rsp_configured,
   // configuration port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [csa_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [csa_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [csa_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);

   // Only slots below the active-slot limit can ever be granted and a
   // release names a slot below 128, so slots past GRANT_LIMIT are never
   // marked and need no storage.
   localparam int MAP_BITS = (SLOT_COUNT < csa_pkg::GRANT_LIMIT) ?
                             SLOT_COUNT : csa_pkg::GRANT_LIMIT;
   localparam int IDX_W    = $clog2(MAP_BITS);

   // ---------------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------------
   logic [csa_pkg::ACTIVE_W-1:0] active_slots_ff;
   logic [csa_pkg::ACTIVE_W-1:0] active_slots_in;
   logic                         csr_write;
   logic                         csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[csa_pkg::CSR_ADDR_W-1:2] == csa_pkg::REG_ACTIVE_SLOTS);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      active_slots_in = active_slots_ff;
      if (csr_write && csr_hit) begin
         active_slots_in = csr_pwdata[csa_pkg::ACTIVE_W-1:0];
      end
   end

   // Read back: the register zero-extended, anything else reads zero.
   assign csr_prdata = csr_hit ? csa_pkg::CSR_DATA_W'(active_slots_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_slots_ff <= '0;
      end else begin
         active_slots_ff <= active_slots_in;
      end
   end

   // ---------------------------------------------------------------------
   // Input register and handshake
   // ---------------------------------------------------------------------
   logic                         in_valid_ff;
   logic                         in_valid_in;
   csa_pkg::op_type              in_op_ff;
   logic                         in_ctl_ff;
   logic [csa_pkg::SLOT_W-1:0]   in_slot_ff;
   logic                         req_take;
   logic                         advance;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;

   // Move the held word forward when the result register is empty or drains.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Payload: load on accept, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= csa_pkg::op_type'(req_op);
         in_ctl_ff  <= req_is_control;
         in_slot_ff <= req_slot_in;
      end
   end

   // ---------------------------------------------------------------------
   // Allocation logic
   // ---------------------------------------------------------------------
   logic [MAP_BITS-1:0]          busy_map_ff;
   logic [MAP_BITS-1:0]          busy_map_in;
   logic                         control_busy_ff;
   logic                         control_busy_in;
   logic                         configured_ff;
   logic                         configured_in;

   logic [MAP_BITS-1:0]          free_map;
   logic [MAP_BITS-1:0]          first_free;
   logic [IDX_W-1:0]             first_idx;
   logic                         any_free;
   logic                         grant_ok;
   logic [MAP_BITS-1:0]          release_vec;

   csa_pkg::status_type          status_calc;
   logic [csa_pkg::SLOT_W-1:0]   slot_calc;
   logic                         has_slot;

   // Lowest zero bit of the busy map as a one-hot vector, then its index.
   assign free_map   = ~busy_map_ff;
   assign first_free = free_map & (~free_map + MAP_BITS'(1));
   assign any_free   = |free_map;

   always_comb begin
      first_idx = '0;
      for (int i = 0; i < MAP_BITS; i++) begin
         if (first_free[i]) begin
            first_idx = first_idx | IDX_W'(i);
         end
      end
   end

   assign grant_ok = any_free &&
                     (csa_pkg::ACTIVE_W'(first_idx) < active_slots_ff);

   // A release past the map shifts out to zero and leaves the map alone.
   assign release_vec = MAP_BITS'(1) << in_slot_ff;

   always_comb begin
      busy_map_in     = busy_map_ff;
      control_busy_in = control_busy_ff;
      configured_in   = configured_ff;
      status_calc     = csa_pkg::STATUS_OK;
      slot_calc       = '0;
      has_slot        = 1'b0;
      if (advance) begin
         case (in_op_ff)
            csa_pkg::OP_ACQUIRE: begin
               if (in_ctl_ff) begin
                  // Control acquire marks slot 0 even when refused.
                  busy_map_in[0] = 1'b1;
                  if (control_busy_ff) begin
                     status_calc = csa_pkg::STATUS_CONTROL_BUSY;
                  end else begin
                     control_busy_in = 1'b1;
                     has_slot        = 1'b1;
                  end
               end else if (grant_ok) begin
                  busy_map_in = busy_map_ff | first_free;
                  slot_calc   = first_idx[csa_pkg::SLOT_W-1:0];
                  has_slot    = 1'b1;
               end else begin
                  status_calc = csa_pkg::STATUS_NO_SLOT;
               end
            end
            csa_pkg::OP_RELEASE: begin
               has_slot = 1'b1;
               if (in_ctl_ff) begin
                  // Slot 0 stays marked; only the flags change.
                  control_busy_in = 1'b0;
                  configured_in   = 1'b1;
               end else begin
                  busy_map_in = busy_map_ff & ~release_vec;
                  slot_calc   = in_slot_ff;
               end
            end
            csa_pkg::OP_CLEAR: begin
               busy_map_in = '0;
            end
            default: begin
               // unused code: no state change, empty result
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_map_ff     <= '0;
         control_busy_ff <= 1'b0;
         configured_ff   <= 1'b0;
      end else begin
         busy_map_ff     <= busy_map_in;
         control_busy_ff <= control_busy_in;
         configured_ff   <= configured_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   logic [csa_pkg::STATUS_W-1:0]   rsp_status_ff;
   logic [csa_pkg::SLOT_W-1:0]     rsp_slot_ff;
   logic [csa_pkg::IRQ_WORD_W-1:0] rsp_irq_word_ff;
   logic [csa_pkg::MASK_W-1:0]     rsp_mask_ff;
   logic                           rsp_configured_ff;

   always_comb begin
      rsp_valid_in = 1'b0;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_stall) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the payload while stalled; load a fresh word on advance.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff     <= status_calc;
         rsp_slot_ff       <= slot_calc;
         rsp_irq_word_ff   <= has_slot ?
                              slot_calc[csa_pkg::SLOT_W-1:csa_pkg::BIT_SEL_W] : '0;
         rsp_mask_ff       <= has_slot ?
                              (csa_pkg::MASK_W'(1) << slot_calc[csa_pkg::BIT_SEL_W-1:0])
                              : '0;
         rsp_configured_ff <= configured_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot_out     = rsp_slot_ff;
   assign rsp_irq_word     = rsp_irq_word_ff;
   assign rsp_irq_bit_mask = rsp_mask_ff;
   assign rsp_configured   = rsp_configured_ff;

endmodule

### dv/command_slot_allocator_tb.sv
// ----------------------------------------------------------------------------
// Command slot allocator testbench
// Sends request words with random gaps against random result stalls, keeps a
// private copy of the busy map, control flags and active_slots to predict every
// reply, and compares each reply field by field. active_slots is rewritten
// over the APB port between phases, from zero through the 8-bit maximum.
// ----------------------------------------------------------------------------
module command_slot_allocator_tb;

   localparam int OP_W          = csa_pkg::OP_W;
   localparam int SLOT_W        = csa_pkg::SLOT_W;
   localparam int STATUS_W      = csa_pkg::STATUS_W;
   localparam int IRQ_WORD_W    = csa_pkg::IRQ_WORD_W;
   localparam int MASK_W        = csa_pkg::MASK_W;
   localparam int BIT_SEL_W     = csa_pkg::BIT_SEL_W;
   localparam int ACTIVE_W      = csa_pkg::ACTIVE_W;
   localparam int CSR_DATA_W    = csa_pkg::CSR_DATA_W;
   localparam int CSR_ADDR_W    = csa_pkg::CSR_ADDR_W;

   localparam int SLOTS         = 128;
   localparam int PHASE_WORDS   = 200;
   localparam int HOLD_CYCLES   = 200;
   // reply passes the input and result registers after acceptance; leave a margin
   localparam int SETTLE_CYCLES = 4;
   localparam int CLOCK_HALF    = 6;
   // far beyond the slowest legal run
   localparam int TIMEOUT       = 2 * CLOCK_HALF * 400000;

   typedef struct {
      csa_pkg::status_type     status;
      logic [SLOT_W-1:0]       slot;
      logic [IRQ_WORD_W-1:0]   irq_word;
      logic [MASK_W-1:0]       bit_mask;
      logic                    configured;
   } reply_type;

   // Shadow of the allocator: predicts each reply and checks what comes back.
   class allocation_ledger;
      logic [SLOTS-1:0]    busy_map;
      bit                  control_busy;
      bit                  configured;
      logic [ACTIVE_W-1:0] active_slots;
      reply_type           awaited_replies[$];
      int                  fail_count;
      int                  words_seen;
      int                  replies_checked;
      int                  grants;
      int                  refusals;

      function new();
         busy_map        = '0;
         control_busy    = 1'b0;
         configured      = 1'b0;
         active_slots    = '0;
         fail_count      = 0;
         words_seen      = 0;
         replies_checked = 0;
         grants          = 0;
         refusals        = 0;
      endfunction

      function void note_request(csa_pkg::op_type op, logic control,
                                 logic [SLOT_W-1:0] slot_in);
         reply_type r;
         int        first_free;
         int        granted;
         r.status   = csa_pkg::STATUS_OK;
         r.slot     = '0;
         r.irq_word = '0;
         r.bit_mask = '0;
         granted    = -1;
         words_seen++;
         case (op)
            csa_pkg::OP_ACQUIRE: begin
               if (control) begin
                  // slot 0 gets marked even when the control acquire is refused
                  busy_map[0] = 1'b1;
                  if (control_busy) begin
                     r.status = csa_pkg::STATUS_CONTROL_BUSY;
                  end else begin
                     control_busy = 1'b1;
                     granted      = 0;
                  end
               end else begin
                  first_free = SLOTS;
                  for (int i = SLOTS - 1; i >= 0; i--)
                     if (!busy_map[i]) first_free = i;
                  if (first_free < SLOTS && first_free < int'(active_slots)) begin
                     busy_map[first_free] = 1'b1;
                     granted              = first_free;
                  end else begin
                     r.status = csa_pkg::STATUS_NO_SLOT;
                  end
               end
               if (r.status == csa_pkg::STATUS_OK) grants++;
               else refusals++;
            end
            csa_pkg::OP_RELEASE: begin
               if (control) begin
                  // control release leaves slot 0 marked
                  control_busy = 1'b0;
                  configured   = 1'b1;
                  granted      = 0;
               end else begin
                  busy_map[slot_in] = 1'b0;
                  granted           = slot_in;
               end
            end
            csa_pkg::OP_CLEAR: busy_map = '0;
            default: ;
         endcase
         if (granted >= 0) begin
            r.slot     = granted[SLOT_W-1:0];
            r.irq_word = granted[SLOT_W-1:BIT_SEL_W];
            r.bit_mask = 32'd1 << granted[BIT_SEL_W-1:0];
         end
         r.configured = configured;
         awaited_replies.push_back(r);
      endfunction

      function void compare_field(string name, logic [MASK_W-1:0] want,
                                  logic [MASK_W-1:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
         end
      endfunction

      function void check_reply(reply_type got);
         reply_type want;
         if (awaited_replies.size() == 0) begin
            $error("reply word with no request outstanding (status %0d, slot %0d)",
                   got.status, got.slot);
            fail_count++;
            return;
         end
         want = awaited_replies.pop_front();
         replies_checked++;
         compare_field("status", want.status, got.status);
         compare_field("slot_out", want.slot, got.slot);
         compare_field("irq_word", want.irq_word, got.irq_word);
         compare_field("irq_bit_mask", want.bit_mask, got.bit_mask);
         compare_field("configured", want.configured, got.configured);
      endfunction
   endclass

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic [OP_W-1:0]       req_op         = '0;
   logic                  req_is_control = 1'b0;
   logic [SLOT_W-1:0]     req_slot_in    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [SLOT_W-1:0]     rsp_slot_out;
   logic [IRQ_WORD_W-1:0] rsp_irq_word;
   logic [MASK_W-1:0]     rsp_irq_bit_mask;
   logic                  rsp_configured;
   logic                  csr_psel       = 1'b0;
   logic                  csr_penable    = 1'b0;
   logic                  csr_pwrite     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr      = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata     = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   allocation_ledger ledger;

   // idle odds in percent for each side, and the long receiver hold-off
   int gap_pct       = 0;
   int stall_pct     = 0;
   int hold_cycles   = 0;
   int settings_seen = 0;

   command_slot_allocator #(
      .SLOT_COUNT(SLOTS)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_is_control  (req_is_control),
      .req_slot_in     (req_slot_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_slot_out    (rsp_slot_out),
      .rsp_irq_word    (rsp_irq_word),
      .rsp_irq_bit_mask(rsp_irq_bit_mask),
      .rsp_configured  (rsp_configured),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #CLOCK_HALF clock = ~clock;

   // Reply side: check the word taken at this edge, then pick the next stall.
   // A pending hold-off wins over the random stall and counts down here.
   always @(posedge clock) begin : reply_monitor
      reply_type seen;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen.status     = csa_pkg::status_type'(rsp_status);
            seen.slot       = rsp_slot_out;
            seen.irq_word   = rsp_irq_word;
            seen.bit_mask   = rsp_irq_bit_mask;
            seen.configured = rsp_configured;
            ledger.check_reply(seen);
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // Offer one request word after a random gap; hold it until accepted.
   task automatic send_word(csa_pkg::op_type op, logic control,
                            logic [SLOT_W-1:0] slot_in);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_is_control <= control;
      req_slot_in    <= slot_in;
      do @(posedge clock); while (req_stall);
      ledger.note_request(op, control, slot_in);
   endtask

   // Drop valid and wait until every predicted reply has been checked.
   task automatic drain_replies();
      req_valid <= 1'b0;
      while (ledger.awaited_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One APB transfer to the active_slots register: setup, access, then idle.
   task automatic csr_access(input logic write, input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {csa_pkg::REG_ACTIVE_SLOTS, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Write active_slots with the block idle, then read it back.
   task automatic set_active_slots(logic [ACTIVE_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      drain_replies();
      csr_access(1'b1, CSR_DATA_W'(value), readback);
      ledger.active_slots = value;
      settings_seen++;
      csr_access(1'b0, '0, readback);
      if (readback[ACTIVE_W-1:0] !== value) begin
         $error("active_slots readback mismatch: expected 0x%0h, got 0x%0h",
                value, readback[ACTIVE_W-1:0]);
         ledger.fail_count++;
      end
   endtask

   // One random phase. Most words are acquires and releases aimed at slots
   // that can be busy; fill phases leave out clears so the map can run full.
   task automatic run_phase(logic [ACTIVE_W-1:0] active, int acquire_pct,
                            bit allow_clear, int send_gap, int recv_stall,
                            bit long_hold);
      csa_pkg::op_type   op;
      logic              control;
      logic [SLOT_W-1:0] slot_in;
      int                dice;
      int                span;
      set_active_slots(active);
      gap_pct   = send_gap;
      stall_pct = recv_stall;
      span      = (active == 0 || active > SLOTS) ? SLOTS : int'(active);
      // back up the whole pipe while the sender keeps pushing words
      if (long_hold) hold_cycles = HOLD_CYCLES;
      for (int n = 0; n < PHASE_WORDS; n++) begin
         // pause the sender mid-phase until every reply is home
         if (n == PHASE_WORDS / 2) drain_replies();
         control = 1'b0;
         slot_in = SLOT_W'($urandom_range(99) < 70 ? $urandom_range(span - 1, 0)
                                                   : $urandom_range(SLOTS - 1, 0));
         if ($urandom_range(99) < acquire_pct) begin
            op = csa_pkg::OP_ACQUIRE;
         end else begin
            dice = $urandom_range(99);
            if (dice < 55) begin
               op = csa_pkg::OP_RELEASE;
            end else if (dice < 70) begin
               op      = csa_pkg::OP_ACQUIRE;
               control = 1'b1;
            end else if (dice < 83) begin
               op      = csa_pkg::OP_RELEASE;
               control = 1'b1;
            end else if (dice < 95) begin
               op      = allow_clear ? csa_pkg::OP_CLEAR : csa_pkg::OP_RELEASE;
               control = allow_clear ? 1'($urandom_range(1, 0)) : 1'b0;
            end else begin
               op      = csa_pkg::OP_NONE;
               control = 1'($urandom_range(1, 0));
            end
         end
         send_word(op, control, slot_in);
      end
   endtask

   initial begin : stimulus
      ledger = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // active_slots is zero out of reset: refuse every normal acquire
      send_word(csa_pkg::OP_ACQUIRE, 1'b0, 7'd0);
      // control release with no control outstanding still sets configured
      send_word(csa_pkg::OP_RELEASE, 1'b1, 7'd127);
      send_word(csa_pkg::OP_ACQUIRE, 1'b1, 7'd0);
      // second control acquire: control slot busy, slot 0 stays marked
      send_word(csa_pkg::OP_ACQUIRE, 1'b1, 7'd127);
      // unused op code: no state change, empty reply
      send_word(csa_pkg::OP_NONE, 1'b1, 7'd127);
      send_word(csa_pkg::OP_NONE, 1'b0, 7'd0);

      set_active_slots(8'd128);
      // slot 0 is held by the control command, so grant 1 then 2
      send_word(csa_pkg::OP_ACQUIRE, 1'b0, 7'd0);
      send_word(csa_pkg::OP_ACQUIRE, 1'b0, 7'd127);
      // normal release of slot 0 clears the control mark
      send_word(csa_pkg::OP_RELEASE, 1'b0, 7'd0);
      send_word(csa_pkg::OP_ACQUIRE, 1'b0, 7'd0);
      // release of a slot that is already free
      send_word(csa_pkg::OP_RELEASE, 1'b0, 7'd127);
      send_word(csa_pkg::OP_RELEASE, 1'b0, 7'd2);
      send_word(csa_pkg::OP_RELEASE, 1'b0, 7'd2);
      send_word(csa_pkg::OP_RELEASE, 1'b1, 7'd0);
      send_word(csa_pkg::OP_ACQUIRE, 1'b0, 7'd0);
      // clear ignores is_control and slot_in, keeps both flags
      send_word(csa_pkg::OP_CLEAR, 1'b1, 7'd127);
      send_word(csa_pkg::OP_ACQUIRE, 1'b0, 7'd0);
      send_word(csa_pkg::OP_RELEASE, 1'b1, 7'd0);

      set_active_slots(8'd1);
      // slot 0 taken, first free slot 1 is at the active limit
      send_word(csa_pkg::OP_ACQUIRE, 1'b0, 7'd0);
      send_word(csa_pkg::OP_RELEASE, 1'b0, 7'd0);
      send_word(csa_pkg::OP_ACQUIRE, 1'b0, 7'd0);
      send_word(csa_pkg::OP_CLEAR, 1'b0, 7'd0);

      // receiver idles more than the sender
      run_phase(8'd128, 60, 1'b1, 36, 63, 1'b0);
      run_phase(8'd255, 88, 1'b0, 36, 63, 1'b1);
      run_phase(8'd1, 55, 1'b1, 36, 63, 1'b0);
      // sender idles more than the receiver
      run_phase(8'd5, 60, 1'b1, 63, 36, 1'b1);
      run_phase(8'd0, 50, 1'b1, 63, 36, 1'b0);
      run_phase(8'd128, 88, 1'b0, 63, 36, 1'b0);
      // both sides at full rate, the first phase with a long receiver hold-off
      run_phase(8'($urandom_range(127, 2)), 60, 1'b1, 0, 0, 1'b1);
      run_phase(8'd32, 65, 1'b1, 0, 0, 1'b0);

      drain_replies();
      $display("Covered %0d request words over %0d active_slots settings.",
               ledger.words_seen, settings_seen);
      $display("Acquires: %0d granted, %0d refused; %0d replies compared.",
               ledger.grants, ledger.refusals, ledger.replies_checked);
      if (ledger.fail_count == 0 && ledger.awaited_replies.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin : watchdog
      #TIMEOUT;
      $display("FAILURE");
      $finish;
   end

endmodule

### command_slot_allocator.f
design/csa_pkg.sv
design/command_slot_allocator.sv
dv/command_slot_allocator_tb.sv
